// ===== hw/rtl/pidtw_pkg.sv =====
// Shared types, constants and field layout for the PID error twiddle tuner.
`default_nettype none
package pidtw_pkg;

    localparam int CTE_W       = 16;
    localparam int SUM_W       = 48;
    localparam int DERIV_W     = 17;
    localparam int GAIN_W      = 32;
    localparam int INIT_W      = 31;
    localparam int CNT_W       = 16;
    localparam int ROUND_W     = 16;
    localparam int PH_W        = 2;
    localparam int CMD_W       = 2;
    localparam int SQ_W        = 31;
    localparam int NUM_GAINS   = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 31;

    // Output beat layout, lowest field first.
    localparam int OUT_PROP_LSB    = 0;
    localparam int OUT_SUM_LSB     = OUT_PROP_LSB + CTE_W;
    localparam int OUT_DERIV_LSB   = OUT_SUM_LSB + SUM_W;
    localparam int OUT_GP_LSB      = OUT_DERIV_LSB + DERIV_W;
    localparam int OUT_GI_LSB      = OUT_GP_LSB + GAIN_W;
    localparam int OUT_GD_LSB      = OUT_GI_LSB + GAIN_W;
    localparam int OUT_PHASE_LSB   = OUT_GD_LSB + GAIN_W;
    localparam int OUT_RESTART_BIT = OUT_PHASE_LSB + PH_W;
    localparam int OUT_ROUND_LSB   = OUT_RESTART_BIT + 1;
    localparam int OUT_USED_W      = OUT_ROUND_LSB + ROUND_W;
    localparam int OUT_W           = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W       = OUT_W - OUT_USED_W;

    // Divide by five: (z * magic) >> 34 is exact for any 32-bit z.
    localparam logic [31:0] DIV5_MAGIC = 32'hCCCC_CCCD;
    localparam int          DIV5_SHIFT = 34;
    localparam int          PROD_W     = 64;
    localparam int          Q_W        = PROD_W - DIV5_SHIFT;

    localparam logic [INIT_W-1:0] STEP_TOL_RESET = 31'd328;
    localparam logic [CNT_W-1:0]  SETTLE_RESET   = 16'd200;
    localparam logic [CNT_W-1:0]  RUN_RESET      = 16'd2000;

    typedef logic [1:0] gain_sel_t;
    localparam gain_sel_t LAST_GAIN = gain_sel_t'(NUM_GAINS - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_INIT   = 2'd1,
        CMD_RESUME = 2'd2
    } cmd_t;

    typedef enum logic [PH_W-1:0] {
        PH_OFF     = 2'd0,
        PH_RUN     = 2'd1,
        PH_STANDBY = 2'd2
    } tune_phase_t;

    typedef enum logic [1:0] {
        GP_RAISE = 2'd0,
        GP_LOWER = 2'd1,
        GP_CHECK = 2'd2
    } gain_phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KP_INITIAL     = 3'd0,
        CFG_KI_INITIAL     = 3'd1,
        CFG_KD_INITIAL     = 3'd2,
        CFG_STEP_TOLERANCE = 3'd3,
        CFG_SETTLE_SAMPLES = 3'd4,
        CFG_RUN_SAMPLES    = 3'd5,
        CFG_TUNE_ENABLE    = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STEP_INIT = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2
    } step_op_t;

    typedef struct packed {
        logic                             valid;
        step_op_t                         op;
        gain_sel_t                        lane;
        logic [GAIN_W-1:0]                dp;
        logic [NUM_GAINS-1:0][INIT_W-1:0] init_gain;
    } step_req_t;

    typedef struct packed {
        logic              valid;
        gain_sel_t         lane;
        logic [GAIN_W-1:0] value;
    } step_wr_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pid_error_twiddle_tuner.sv =====
// Top level: PID error tracker with twiddle gain tuning on stream ports.
`default_nettype none
// Each input beat carries a command in s_tuser (sample, init, resume) and a signed
// Q8.8 cross-track error in s_tdata; each accepted beat yields exactly one output
// beat with the P, I and D error terms, the three Q16.16 gains, the tuning phase,
// the restart flag and the twiddle round count. Items flow at one per clock while
// the step pipeline is idle and m_tready is high: the square of the sample is
// formed as the beat enters the input register, and the error terms, the run
// bookkeeping and the twiddle step on the gains are all done between the input
// register and the output register; the input register can take the next beat
// while a result waits on m_tready. The gain steps go through a small shared
// divide-by-ten pipeline, and the input stalls while it runs: an init beat holds
// the next beat through three steps of 0.3*K, and a rescale of a gain step (by
// 1.1 or 0.9) holds it until written back. Over a run of thousands of samples the
// rate stays near one beat per cycle. Configuration writes are always taken
// (cfg_ready is tied high) and should only arrive while no beat is in flight.
module pid_error_twiddle_tuner (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // s_tdata: cte[15:0]
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [pidtw_pkg::CTE_W-1:0]           s_tdata,
    // s_tuser: command[1:0]
    input  logic [pidtw_pkg::CMD_W-1:0]           s_tuser,
    // m_tdata: prop_error[15:0], integral_error[63:16], deriv_error[80:64],
    //   gain_p[112:81], gain_i[144:113], gain_d[176:145], tuning_phase[178:177],
    //   restart_request[179], round_count[195:180], zero pad[199:196]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [pidtw_pkg::OUT_W-1:0]           m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pidtw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pidtw_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import pidtw_pkg::*;

    // Configuration registers
    logic [INIT_W-1:0] kp_init_reg;
    logic [INIT_W-1:0] ki_init_reg;
    logic [INIT_W-1:0] kd_init_reg;
    logic [INIT_W-1:0] step_tol_reg;
    logic [CNT_W-1:0]  settle_reg;
    logic [CNT_W-1:0]  run_len_reg;
    logic              tune_en_reg;

    // Input register
    logic                    in_vld_reg;
    cmd_t                    in_cmd_reg;
    logic signed [CTE_W-1:0] in_cte_reg;
    logic [SQ_W-1:0]         in_sq_reg;
    logic signed [CTE_W-1:0] s_cte;
    logic signed [31:0]      s_sq;

    // Tracker and tuner state
    logic signed [CTE_W-1:0]  last_reg,   last_next;
    logic signed [SUM_W-1:0]  esum_reg,   esum_next;
    logic [CNT_W-1:0]         cnt_reg,    cnt_next;
    logic [SUM_W-1:0]         runerr_reg, runerr_next;
    logic [SUM_W-1:0]         best_reg,   best_next;
    logic signed [GAIN_W-1:0] gains_reg   [NUM_GAINS];
    logic signed [GAIN_W-1:0] gains_next  [NUM_GAINS];
    logic [GAIN_W-1:0]        steps_reg   [NUM_GAINS];
    gain_phase_t              gphase_reg  [NUM_GAINS];
    gain_phase_t              gphase_next [NUM_GAINS];
    gain_sel_t                active_reg, active_next;
    tune_phase_t              phase_reg,  phase_next;
    logic [ROUND_W-1:0]       rounds_reg, rounds_next;

    // Output register
    logic             out_vld_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic                      advance;
    logic                      step_busy;
    step_req_t                 step_req;
    step_wr_t                  step_wr;
    logic                      req_want;

    logic signed [DERIV_W-1:0] deriv_calc;
    logic signed [DERIV_W-1:0] deriv_out;
    logic                      restart;
    logic [SUM_W:0]            esum_wide;
    logic signed [SUM_W-1:0]   esum_sat;
    logic [CNT_W-1:0]          cnt_inc;
    logic [SUM_W:0]            acc_wide;
    logic [SUM_W-1:0]          runerr_acc;
    logic                      counted;
    logic                      run_end;
    logic [GAIN_W+1:0]         step_sum;
    logic                      over_tol;
    gain_sel_t                 g;
    logic [GAIN_W+2:0]         p_ext;
    logic [GAIN_W+2:0]         dp_ext;
    logic signed [GAIN_W+2:0]  gain_plus;
    logic signed [GAIN_W+2:0]  gain_minus2;
    logic                      better;
    logic                      move_on;
    logic [OUT_W-1:0]          result_data;

    function automatic logic signed [GAIN_W-1:0] sat_gain(input logic signed [GAIN_W+2:0] v);
        logic [3:0] top;
        top = v[GAIN_W+2:GAIN_W-1];
        if ((top == 4'b0000) || (top == 4'b1111))
            return v[GAIN_W-1:0];
        else if (v[GAIN_W+2])
            return {1'b1, {(GAIN_W-1){1'b0}}};
        else
            return {1'b0, {(GAIN_W-1){1'b1}}};
    endfunction

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_init_reg  <= '0;
            ki_init_reg  <= '0;
            kd_init_reg  <= '0;
            step_tol_reg <= STEP_TOL_RESET;
            settle_reg   <= SETTLE_RESET;
            run_len_reg  <= RUN_RESET;
            tune_en_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_KP_INITIAL:     kp_init_reg  <= cfg_data;
                CFG_KI_INITIAL:     ki_init_reg  <= cfg_data;
                CFG_KD_INITIAL:     kd_init_reg  <= cfg_data;
                CFG_STEP_TOLERANCE: step_tol_reg <= cfg_data;
                CFG_SETTLE_SAMPLES: settle_reg   <= cfg_data[CNT_W-1:0];
                CFG_RUN_SAMPLES:    run_len_reg  <= cfg_data[CNT_W-1:0];
                CFG_TUNE_ENABLE:    tune_en_reg  <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // ---------------------------------------------------------------- handshake
    // Advance the held beat when the step pipeline is quiet and the output
    // register is free or being drained this cycle.
    assign advance  = in_vld_reg && !step_busy && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    assign s_cte = s_tdata;
    assign s_sq  = s_cte * s_cte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tready)
            in_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg <= cmd_t'(s_tuser);
            in_cte_reg <= s_cte;
            in_sq_reg  <= s_sq[SQ_W-1:0];
        end
    end

    // ---------------------------------------------------------------- datapath
    assign deriv_calc = {in_cte_reg[CTE_W-1], in_cte_reg} - {last_reg[CTE_W-1], last_reg};

    // Integral: saturate to the signed 48-bit range.
    assign esum_wide = {esum_reg[SUM_W-1], esum_reg}
                     + {{(SUM_W+1-CTE_W){in_cte_reg[CTE_W-1]}}, in_cte_reg};
    assign esum_sat  = (esum_wide[SUM_W] == esum_wide[SUM_W-1]) ? esum_wide[SUM_W-1:0]
                     : (esum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}});

    assign cnt_inc    = (cnt_reg != '1) ? cnt_reg + 16'd1 : cnt_reg;
    assign counted    = cnt_inc > settle_reg;
    assign run_end    = cnt_inc >= run_len_reg;
    assign acc_wide   = {1'b0, runerr_reg} + {{(SUM_W+1-SQ_W){1'b0}}, in_sq_reg};
    assign runerr_acc = counted ? (acc_wide[SUM_W] ? '1 : acc_wide[SUM_W-1:0]) : runerr_reg;

    assign step_sum = {2'b00, steps_reg[0]} + {2'b00, steps_reg[1]} + {2'b00, steps_reg[2]};
    assign over_tol = step_sum > {3'b000, step_tol_reg};

    assign g           = (active_reg > LAST_GAIN) ? '0 : active_reg;
    assign p_ext       = {{3{gains_reg[g][GAIN_W-1]}}, gains_reg[g]};
    assign dp_ext      = {3'b000, steps_reg[g]};
    assign gain_plus   = p_ext + dp_ext;
    assign gain_minus2 = p_ext - {dp_ext[GAIN_W+1:0], 1'b0};
    assign better      = runerr_acc < best_reg;

    always_comb
    begin
        last_next   = last_reg;
        esum_next   = esum_reg;
        cnt_next    = cnt_reg;
        runerr_next = runerr_reg;
        best_next   = best_reg;
        for (int i = 0; i < NUM_GAINS; i++)
        begin
            gains_next[i]  = gains_reg[i];
            gphase_next[i] = gphase_reg[i];
        end
        active_next = active_reg;
        phase_next  = phase_reg;
        rounds_next = rounds_reg;
        deriv_out   = '0;
        restart     = 1'b0;
        move_on     = 1'b0;
        req_want    = 1'b0;
        step_req    = '0;
        step_req.lane = g;
        step_req.dp   = steps_reg[g];
        step_req.init_gain[0] = kp_init_reg;
        step_req.init_gain[1] = ki_init_reg;
        step_req.init_gain[2] = kd_init_reg;

        unique case (in_cmd_reg)
            CMD_SAMPLE:
            begin
                deriv_out = deriv_calc;
                last_next = in_cte_reg;
                esum_next = esum_sat;
                if (phase_reg == PH_RUN)
                begin
                    cnt_next    = cnt_inc;
                    runerr_next = runerr_acc;
                    if (run_end)
                    begin
                        cnt_next    = '0;
                        runerr_next = '0;
                        if (over_tol)
                        begin
                            restart     = 1'b1;
                            active_next = g;
                            if (rounds_reg != '1)
                                rounds_next = rounds_reg + 16'd1;
                            // One twiddle step on the active gain.
                            unique case (gphase_reg[g])
                                GP_RAISE:
                                begin
                                    gains_next[g]  = sat_gain(gain_plus);
                                    gphase_next[g] = GP_LOWER;
                                end
                                GP_LOWER:
                                begin
                                    if (better)
                                    begin
                                        best_next      = runerr_acc;
                                        req_want       = 1'b1;
                                        step_req.op    = STEP_UP;
                                        gphase_next[g] = GP_RAISE;
                                        move_on        = 1'b1;
                                    end
                                    else
                                    begin
                                        gains_next[g]  = sat_gain(gain_minus2);
                                        gphase_next[g] = GP_CHECK;
                                    end
                                end
                                default:
                                begin
                                    req_want = 1'b1;
                                    if (better)
                                    begin
                                        best_next   = runerr_acc;
                                        step_req.op = STEP_UP;
                                    end
                                    else
                                    begin
                                        gains_next[g] = sat_gain(gain_plus);
                                        step_req.op   = STEP_DOWN;
                                    end
                                    gphase_next[g] = GP_RAISE;
                                    move_on        = 1'b1;
                                end
                            endcase
                            if (move_on)
                            begin
                                if (g == LAST_GAIN)
                                begin
                                    active_next = '0;
                                    phase_next  = PH_STANDBY;
                                end
                                else
                                begin
                                    active_next = g + 2'd1;
                                end
                            end
                        end
                        else
                        begin
                            phase_next = PH_OFF;
                        end
                    end
                end
            end
            CMD_INIT:
            begin
                gains_next[0] = {1'b0, kp_init_reg};
                gains_next[1] = {1'b0, ki_init_reg};
                gains_next[2] = {1'b0, kd_init_reg};
                for (int i = 0; i < NUM_GAINS; i++)
                    gphase_next[i] = GP_RAISE;
                last_next   = '0;
                esum_next   = '0;
                runerr_next = '0;
                cnt_next    = '0;
                best_next   = '1;
                active_next = '0;
                rounds_next = '0;
                phase_next  = tune_en_reg ? PH_RUN : PH_OFF;
                req_want    = 1'b1;
                step_req.op = STEP_INIT;
            end
            CMD_RESUME:
            begin
                if (phase_reg == PH_STANDBY)
                    phase_next = PH_RUN;
            end
            default: ;
        endcase

        step_req.valid = req_want && advance;
    end

    pidtw_step_unit u_step (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (step_req),
        .wr   (step_wr),
        .busy (step_busy)
    );

    // ---------------------------------------------------------------- state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= '0;
            esum_reg   <= '0;
            cnt_reg    <= '0;
            runerr_reg <= '0;
            best_reg   <= '1;
            for (int i = 0; i < NUM_GAINS; i++)
            begin
                gains_reg[i]  <= '0;
                steps_reg[i]  <= '0;
                gphase_reg[i] <= GP_RAISE;
            end
            active_reg <= '0;
            phase_reg  <= PH_OFF;
            rounds_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                last_reg   <= last_next;
                esum_reg   <= esum_next;
                cnt_reg    <= cnt_next;
                runerr_reg <= runerr_next;
                best_reg   <= best_next;
                for (int i = 0; i < NUM_GAINS; i++)
                begin
                    gains_reg[i]  <= gains_next[i];
                    gphase_reg[i] <= gphase_next[i];
                end
                active_reg <= active_next;
                phase_reg  <= phase_next;
                rounds_reg <= rounds_next;
            end
            // Write back a rescaled step; the input stays held until it lands.
            if (step_wr.valid)
                steps_reg[step_wr.lane] <= step_wr.value;
        end
    end

    // ---------------------------------------------------------------- result
    assign result_data = {{OUT_PAD_W{1'b0}}, rounds_next, restart, phase_next,
                          gains_next[2], gains_next[1], gains_next[0],
                          deriv_out, esum_next, last_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (m_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= result_data;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/pidtw_step_unit.sv =====
// Gain step scaler: 0.3*K, 1.1*dp and 0.9*dp with round half up, pipelined.
`default_nettype none
module pidtw_step_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pidtw_pkg::step_req_t req,
    output pidtw_pkg::step_wr_t  wr,
    output logic                 busy
);
    import pidtw_pkg::*;

    logic              pend_vld_reg;
    gain_sel_t         pend_lane_reg;
    logic [INIT_W-1:0] kq_reg [NUM_GAINS];

    logic              iss_vld;
    step_op_t          iss_op;
    gain_sel_t         iss_lane;
    logic [32:0]       iss_y;

    logic              a_vld_reg;
    step_op_t          a_op_reg;
    gain_sel_t         a_lane_reg;
    logic [GAIN_W-1:0] a_dp_reg;
    logic [31:0]       a_z_reg;

    logic              b_vld_reg;
    step_op_t          b_op_reg;
    gain_sel_t         b_lane_reg;
    logic [GAIN_W-1:0] b_dp_reg;
    logic [Q_W-1:0]    b_q_reg;
    logic [PROD_W-1:0] a_prod;
    logic [32:0]       up_sum;

    // Init jobs come from the captured gains; rescale jobs go out at once.
    assign iss_vld  = pend_vld_reg || (req.valid && (req.op != STEP_INIT));
    assign iss_op   = pend_vld_reg ? STEP_INIT : req.op;
    assign iss_lane = pend_vld_reg ? pend_lane_reg : req.lane;

    // floor(y/10) = floor(floor(y/2)/5)
    always_comb
    begin
        unique case (iss_op)
            STEP_INIT: iss_y = {2'b00, kq_reg[0]} + {1'b0, kq_reg[0], 1'b0} + 33'd5;
            STEP_UP:   iss_y = {1'b0, req.dp} + 33'd5;
            STEP_DOWN: iss_y = {1'b0, req.dp} + 33'd4;
            default:   iss_y = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg  <= 1'b0;
            pend_lane_reg <= '0;
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
        end
        else
        begin
            if (req.valid && (req.op == STEP_INIT))
            begin
                pend_vld_reg  <= 1'b1;
                pend_lane_reg <= '0;
            end
            else if (pend_vld_reg)
            begin
                if (pend_lane_reg == LAST_GAIN)
                    pend_vld_reg <= 1'b0;
                pend_lane_reg <= pend_lane_reg + 2'd1;
            end
            a_vld_reg <= iss_vld;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && (req.op == STEP_INIT))
        begin
            for (int i = 0; i < NUM_GAINS; i++)
                kq_reg[i] <= req.init_gain[i];
        end
        else if (pend_vld_reg)
        begin
            for (int i = 0; i < NUM_GAINS - 1; i++)
                kq_reg[i] <= kq_reg[i+1];
        end
        if (iss_vld)
        begin
            a_op_reg   <= iss_op;
            a_lane_reg <= iss_lane;
            a_dp_reg   <= req.dp;
            a_z_reg    <= iss_y[32:1];
        end
        if (a_vld_reg)
        begin
            b_op_reg   <= a_op_reg;
            b_lane_reg <= a_lane_reg;
            b_dp_reg   <= a_dp_reg;
            b_q_reg    <= a_prod[PROD_W-1:DIV5_SHIFT];
        end
    end

    assign a_prod = {32'b0, a_z_reg} * {32'b0, DIV5_MAGIC};
    assign up_sum = {1'b0, b_dp_reg} + {3'b000, b_q_reg};

    always_comb
    begin
        wr.valid = b_vld_reg;
        wr.lane  = b_lane_reg;
        unique case (b_op_reg)
            STEP_INIT: wr.value = {2'b00, b_q_reg};
            STEP_UP:   wr.value = up_sum[32] ? '1 : up_sum[31:0];
            STEP_DOWN: wr.value = b_dp_reg - {2'b00, b_q_reg};
            default:   wr.value = b_dp_reg;
        endcase
    end

    assign busy = pend_vld_reg || a_vld_reg || b_vld_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/pidtw_checker.sv =====
// Port-level checks for the PID error twiddle tuner, bound to the top level.
`default_nettype none
module pidtw_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [pidtw_pkg::OUT_W-1:0] m_tdata
);
    import pidtw_pkg::*;

    logic              beat_restart;
    logic [PH_W-1:0]   beat_phase;
    logic [ROUND_W-1:0] beat_round;

    assign beat_restart = m_tdata[OUT_RESTART_BIT];
    assign beat_phase   = m_tdata[OUT_PHASE_LSB +: PH_W];
    assign beat_round   = m_tdata[OUT_ROUND_LSB +: ROUND_W];

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    // A twiddle step leaves the tuner running or in standby.
    a_restart_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && beat_restart |-> (beat_phase == PH_RUN) || (beat_phase == PH_STANDBY))
        else $error("restart request with tuning off");

    // A twiddle step is always counted.
    a_restart_round: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && beat_restart |-> beat_round != '0)
        else $error("restart request with zero round count");

endmodule

bind pid_error_twiddle_tuner pidtw_checker u_pidtw_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
`default_nettype wire

// ===== verif/tb_pid_error_twiddle_tuner.sv =====
// Self-checking testbench for the PID error tracker with twiddle gain tuning.
module tb_pid_error_twiddle_tuner;
    timeunit 1ns;
    timeprecision 1ps;

    import pidtw_pkg::*;

    localparam int  DIRECTED_ROWS     = 26;
    localparam int  TUNING_ROWS_START = 7;
    localparam int  RANDOM_PHASES     = 8;
    localparam int  ITEMS_PER_PHASE   = 210;
    localparam int  QUIET_LIMIT       = 3000;
    localparam int  IDLE_SETTLE       = 8;
    localparam int  TAIL_CYCLES       = 20;
    localparam int  MAX_REPORTS       = 10;

    localparam longint          GAIN_MAX  = 64'sd2147483647;
    localparam longint          GAIN_MIN  = -64'sd2147483648;
    localparam longint          INTEG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint          INTEG_MIN = -64'sh0000_8000_0000_0000;
    localparam longint unsigned SUM_MASK  = 64'h0000_FFFF_FFFF_FFFF;

    // One output beat, split into its fields.
    typedef struct {
        logic signed [CTE_W-1:0]   prop;
        logic signed [SUM_W-1:0]   integ;
        logic signed [DERIV_W-1:0] deriv;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic [PH_W-1:0]           phase;
        logic                      restart;
        logic [ROUND_W-1:0]        rounds;
    } tuner_out_t;

    // A directed row; when typed is set the error terms and phase are written
    // out by hand and replace what the predictor computes for them.
    typedef struct {
        cmd_t                      cmd;
        logic [CTE_W-1:0]          cte;
        bit                        typed;
        logic signed [CTE_W-1:0]   prop;
        logic signed [SUM_W-1:0]   integ;
        logic signed [DERIV_W-1:0] deriv;
        tune_phase_t               phase;
    } script_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [CTE_W-1:0]       s_tdata   = '0;
    logic [CMD_W-1:0]       s_tuser   = CMD_SAMPLE;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_W-1:0]       m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_KP_INITIAL;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Hand-typed expectation travelling alongside the input beat.
    bit                        row_typed = 1'b0;
    logic signed [CTE_W-1:0]   row_prop  = '0;
    logic signed [SUM_W-1:0]   row_integ = '0;
    logic signed [DERIV_W-1:0] row_deriv = '0;
    tune_phase_t               row_phase = PH_OFF;

    bit quiet_source = 1'b0;
    bit quiet_sink   = 1'b0;
    int sink_hold    = 0;

    int sent_count   = 0;
    int results_seen = 0;
    int mismatches   = 0;

    tuner_out_t pending_results [$];

    // Predictor copy of the tuner: registers.
    int unsigned init_gain [NUM_GAINS] = '{0, 0, 0};
    int unsigned step_tol  = 328;
    int unsigned settle_n  = 200;
    int unsigned run_n     = 2000;
    bit          tune_on   = 1'b1;

    // Predictor copy of the tuner: state.
    logic signed [CTE_W-1:0] last_cte       = '0;
    longint                  integ_sum      = 0;
    int unsigned             run_count      = 0;
    longint unsigned         run_err        = 0;
    longint unsigned         best_score     = SUM_MASK;
    int                      gain_val  [NUM_GAINS] = '{0, 0, 0};
    int unsigned             gain_step [NUM_GAINS] = '{0, 0, 0};
    gain_phase_t             gain_ph   [NUM_GAINS] = '{GP_RAISE, GP_RAISE, GP_RAISE};
    int unsigned             active         = 0;
    tune_phase_t             tphase         = PH_OFF;
    int unsigned             twiddle_rounds = 0;

    // Part one runs on reset settings with hand-typed terms; part two loads a tuning
    // setup that steps all three gains, reaches every twiddle phase, then standby.
    script_row_t script [DIRECTED_ROWS] = '{
        '{CMD_SAMPLE, 16'h7FFF, 1'b1, 16'sd32767, 48'sd32767, 17'sd32767, PH_OFF},
        '{CMD_SAMPLE, 16'h8000, 1'b1, 16'sh8000, -48'sd1, -17'sd65535, PH_OFF},
        '{CMD_SAMPLE, 16'h7FFF, 1'b1, 16'sd32767, 48'sd32766, 17'sd65535, PH_OFF},
        '{CMD_RESUME, 16'h0000, 1'b1, 16'sd32767, 48'sd32766, 17'sd0, PH_OFF},
        '{CMD_INIT,   16'hFFFF, 1'b1, 16'sd0, 48'sd0, 17'sd0, PH_RUN},
        '{CMD_RESUME, 16'h5A5A, 1'b1, 16'sd0, 48'sd0, 17'sd0, PH_RUN},
        '{CMD_SAMPLE, 16'hFFFF, 1'b1, -16'sd1, -48'sd1, -17'sd1, PH_RUN},
        '{CMD_INIT,   16'h0000, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_SAMPLE, 16'h0100, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_SAMPLE, 16'h0100, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_SAMPLE, 16'h0000, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_SAMPLE, 16'h0200, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_SAMPLE, 16'h0000, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_SAMPLE, 16'h0000, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_SAMPLE, 16'h0000, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_SAMPLE, 16'h0400, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_SAMPLE, 16'h0000, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_SAMPLE, 16'h0010, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_SAMPLE, 16'h0000, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_SAMPLE, 16'h0000, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_SAMPLE, 16'h0000, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_SAMPLE, 16'h7FFF, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_SAMPLE, 16'h0000, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_SAMPLE, 16'h8000, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_SAMPLE, 16'h1234, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF},
        '{CMD_RESUME, 16'hEDCB, 1'b0, 16'sd0, 48'sd0, 17'sd0, PH_OFF}
    };

    pid_error_twiddle_tuner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic int clamp_gain(longint v);
        if (v > GAIN_MAX)
            return int'(GAIN_MAX);
        if (v < GAIN_MIN)
            return int'(GAIN_MIN);
        return int'(v);
    endfunction

    // Scale a gain step by num/10, rounded half up, saturating at 32 bits.
    function automatic int unsigned scaled_step(int unsigned dp, int unsigned num);
        longint unsigned r;
        r = (64'(dp) * num + 5) / 10;
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    // One coordinate-descent move on the active gain.
    function automatic void twiddle_gain(longint unsigned err);
        int unsigned g;
        longint      p;
        longint      dp;
        g  = active;
        p  = gain_val[g];
        dp = gain_step[g];
        case (gain_ph[g])
            GP_RAISE:
            begin
                gain_val[g] = clamp_gain(p + dp);
                gain_ph[g]  = GP_LOWER;
            end
            GP_LOWER:
            begin
                if (err < best_score)
                begin
                    best_score   = err;
                    gain_step[g] = scaled_step(gain_step[g], 11);
                    gain_ph[g]   = GP_RAISE;
                    g++;
                end
                else
                begin
                    gain_val[g] = clamp_gain(p - 2 * dp);
                    gain_ph[g]  = GP_CHECK;
                end
            end
            default:
            begin
                if (err < best_score)
                begin
                    best_score   = err;
                    gain_step[g] = scaled_step(gain_step[g], 11);
                end
                else
                begin
                    gain_val[g]  = clamp_gain(p + dp);
                    gain_step[g] = scaled_step(gain_step[g], 9);
                end
                gain_ph[g] = GP_RAISE;
                g++;
            end
        endcase
        // All three gains stepped: park in standby until resumed.
        if (g >= NUM_GAINS)
        begin
            g      = 0;
            tphase = PH_STANDBY;
        end
        active = g;
    endfunction

    // Advance the tuner copy by one input beat and return the beat it emits.
    function automatic tuner_out_t tuner_result(logic [CMD_W-1:0] cmd,
                                                logic signed [CTE_W-1:0] cte);
        tuner_out_t      r;
        longint          s;
        longint unsigned steps_total;
        r.deriv   = '0;
        r.restart = 1'b0;
        if (cmd == CMD_SAMPLE)
        begin
            r.deriv  = DERIV_W'(int'(cte) - int'(last_cte));
            last_cte = cte;
            s = integ_sum + cte;
            if (s > INTEG_MAX)
                s = INTEG_MAX;
            else if (s < INTEG_MIN)
                s = INTEG_MIN;
            integ_sum = s;
            if (tphase == PH_RUN)
            begin
                if (run_count < 32'hFFFF)
                    run_count++;
                // Score only the samples past the settle window.
                if (run_count > settle_n)
                begin
                    run_err += 64'(longint'(cte) * longint'(cte));
                    if (run_err > SUM_MASK)
                        run_err = SUM_MASK;
                end
                if (run_count >= run_n)
                begin
                    steps_total = 64'(gain_step[0]) + gain_step[1] + gain_step[2];
                    if (steps_total > step_tol)
                    begin
                        twiddle_gain(run_err);
                        if (twiddle_rounds < 32'hFFFF)
                            twiddle_rounds++;
                        r.restart = 1'b1;
                    end
                    else
                        tphase = PH_OFF;
                    run_err   = 0;
                    run_count = 0;
                end
            end
        end
        else if (cmd == CMD_INIT)
        begin
            for (int i = 0; i < NUM_GAINS; i++)
            begin
                gain_val[i]  = int'(init_gain[i]);
                gain_step[i] = 32'((64'(init_gain[i]) * 3 + 5) / 10);
                gain_ph[i]   = GP_RAISE;
            end
            last_cte       = '0;
            integ_sum      = 0;
            run_err        = 0;
            run_count      = 0;
            best_score     = SUM_MASK;
            active         = 0;
            twiddle_rounds = 0;
            tphase         = tune_on ? PH_RUN : PH_OFF;
        end
        else if (cmd == CMD_RESUME)
        begin
            if (tphase == PH_STANDBY)
                tphase = PH_RUN;
        end
        r.prop   = last_cte;
        r.integ  = integ_sum[SUM_W-1:0];
        r.gain_p = gain_val[0];
        r.gain_i = gain_val[1];
        r.gain_d = gain_val[2];
        r.phase  = tphase;
        r.rounds = twiddle_rounds[ROUND_W-1:0];
        return r;
    endfunction

    function automatic void write_setting(logic [CFG_INDEX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] v);
        case (idx)
            CFG_KP_INITIAL:     init_gain[0] = v;
            CFG_KI_INITIAL:     init_gain[1] = v;
            CFG_KD_INITIAL:     init_gain[2] = v;
            CFG_STEP_TOLERANCE: step_tol     = v;
            CFG_SETTLE_SAMPLES: settle_n     = v[CNT_W-1:0];
            CFG_RUN_SAMPLES:    run_n        = v[CNT_W-1:0];
            CFG_TUNE_ENABLE:    tune_on      = v[0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic check_field(string name, logic signed [63:0] want,
                               logic signed [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result %0d: %s expected %0d, got %0d",
                         results_seen, name, want, got);
        end
    endtask

    // Predict on every accepted input beat, compare on every accepted output
    // beat. Push before pop so a same-edge pair would still line up.
    always @(posedge clk)
    begin : beat_monitor
        tuner_out_t want;
        tuner_out_t got;
        if (cfg_valid && cfg_ready)
            write_setting(cfg_index, cfg_data);
        if (s_tvalid && s_tready)
        begin
            want = tuner_result(s_tuser, s_tdata);
            if (row_typed)
            begin
                want.prop  = row_prop;
                want.integ = row_integ;
                want.deriv = row_deriv;
                want.phase = row_phase;
            end
            pending_results.push_back(want);
        end
        if (m_tvalid && m_tready)
        begin
            got.prop    = m_tdata[OUT_PROP_LSB +: CTE_W];
            got.integ   = m_tdata[OUT_SUM_LSB +: SUM_W];
            got.deriv   = m_tdata[OUT_DERIV_LSB +: DERIV_W];
            got.gain_p  = m_tdata[OUT_GP_LSB +: GAIN_W];
            got.gain_i  = m_tdata[OUT_GI_LSB +: GAIN_W];
            got.gain_d  = m_tdata[OUT_GD_LSB +: GAIN_W];
            got.phase   = m_tdata[OUT_PHASE_LSB +: PH_W];
            got.restart = m_tdata[OUT_RESTART_BIT];
            got.rounds  = m_tdata[OUT_ROUND_LSB +: ROUND_W];
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d arrived with nothing expected", results_seen);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("prop_error", want.prop, got.prop);
                check_field("integral_error", want.integ, got.integ);
                check_field("deriv_error", want.deriv, got.deriv);
                check_field("gain_p", want.gain_p, got.gain_p);
                check_field("gain_i", want.gain_i, got.gain_i);
                check_field("gain_d", want.gain_d, got.gain_d);
                check_field("tuning_phase", want.phase, got.phase);
                check_field("restart_request", want.restart, got.restart);
                check_field("round_count", want.rounds, got.rounds);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Idle length: mostly none, often short, rarely long.
    function automatic int burst_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Error sample mix: full range, near zero, moderate, and the extremes.
    function automatic logic [CTE_W-1:0] random_cte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return CTE_W'($urandom_range(0, 65535));
        if (r < 70)
            return CTE_W'($urandom_range(0, 511) - 256);
        if (r < 85)
            return CTE_W'($urandom_range(0, 8191) - 4096);
        case ($urandom_range(0, 3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Back-pressure on the result side; hold ready low for a drawn stall length.
    always @(posedge clk)
    begin : sink_pacing
        if (quiet_sink)
            m_tready <= 1'b1;
        else if (sink_hold > 0)
        begin
            m_tready <= 1'b0;
            sink_hold--;
        end
        else
        begin
            sink_hold = burst_gap();
            m_tready <= (sink_hold == 0);
            if (sink_hold > 0)
                sink_hold--;
        end
    end

    // Present one beat after an optional gap and hold it until accepted.
    task automatic send_item(cmd_t cmd, logic [CTE_W-1:0] cte, bit typed,
                             logic signed [CTE_W-1:0] prop,
                             logic signed [SUM_W-1:0] integ,
                             logic signed [DERIV_W-1:0] deriv,
                             tune_phase_t ph);
        int gap;
        gap = quiet_source ? 0 : burst_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= cmd;
        s_tdata   <= cte;
        row_typed <= typed;
        row_prop  <= prop;
        row_integ <= integ;
        row_deriv <= deriv;
        row_phase <= ph;
        do
            @(posedge clk);
        while (!s_tready);
        sent_count++;
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (results_seen < sent_count);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Rewrite every register with the block idle.
    task automatic load_settings(logic [CFG_DATA_W-1:0] kp, logic [CFG_DATA_W-1:0] ki,
                                 logic [CFG_DATA_W-1:0] kd, logic [CFG_DATA_W-1:0] tol,
                                 logic [CNT_W-1:0] settle, logic [CNT_W-1:0] run,
                                 logic enable);
        drain_results();
        repeat (IDLE_SETTLE) @(posedge clk);
        write_reg(CFG_KP_INITIAL, kp);
        write_reg(CFG_KI_INITIAL, ki);
        write_reg(CFG_KD_INITIAL, kd);
        write_reg(CFG_STEP_TOLERANCE, tol);
        write_reg(CFG_SETTLE_SAMPLES, CFG_DATA_W'(settle));
        write_reg(CFG_RUN_SAMPLES, CFG_DATA_W'(run));
        write_reg(CFG_TUNE_ENABLE, CFG_DATA_W'(enable));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Watchdog: end the run when no beat of any kind moves for too long.
    // ---------------------------------------------------------------
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        int   counted;
        int   r;
        cmd_t cmd;
        bit   effective;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: reset settings first, then a tuning setup that steps all three
        // gains, reaches every twiddle phase and lands in standby.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (i == TUNING_ROWS_START)
                load_settings(31'h7FFF_FFFF, 31'h0001_0000, 31'd0, 31'd0,
                              16'd1, 16'd2, 1'b1);
            send_item(script[i].cmd, script[i].cte, script[i].typed, script[i].prop,
                      script[i].integ, script[i].deriv, script[i].phase);
        end

        // Random part: each phase loads a new setup, then streams init-led
        // sample runs with resumes out of standby and a little noise.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: load_settings(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0,
                                 16'd0, 16'd1, 1'b1);
                1: load_settings(31'($urandom_range(0, 1 << 20)),
                                 31'($urandom_range(0, 1 << 20)),
                                 31'($urandom_range(0, 1 << 20)),
                                 31'($urandom_range(0, 4096)),
                                 16'($urandom_range(0, 3)), 16'($urandom_range(1, 6)),
                                 1'b1);
                2: load_settings(31'($urandom()), 31'($urandom()), 31'($urandom()),
                                 31'h7FFF_FFFF, 16'($urandom_range(0, 4)),
                                 16'($urandom_range(2, 8)), 1'b1);
                3: load_settings(31'($urandom()), 31'($urandom()), 31'($urandom()),
                                 31'($urandom()), 16'hFFFF, 16'hFFFF, 1'b0);
                4: load_settings(31'd0, 31'd0, 31'd0, 31'd0, 16'd0, 16'd3, 1'b1);
                5: load_settings(31'($urandom_range(1 << 16, 1 << 24)),
                                 31'($urandom_range(1 << 16, 1 << 24)),
                                 31'($urandom_range(1 << 16, 1 << 24)),
                                 31'($urandom_range(0, 1000)), 16'hFFFF, 16'd1, 1'b1);
                default: load_settings(31'($urandom_range(0, 1 << 28)),
                                       31'($urandom_range(0, 1 << 28)),
                                       31'($urandom_range(0, 1 << 28)),
                                       31'($urandom_range(0, 1 << 16)),
                                       16'($urandom_range(0, 10)),
                                       16'($urandom_range(1, 12)), 1'b1);
            endcase

            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                // Flip between idling and full-rate stretches now and then.
                if (counted % 50 == 0)
                begin
                    quiet_source = ($urandom_range(0, 3) == 0);
                    quiet_sink  <= ($urandom_range(0, 3) == 0);
                end
                // Occasionally hold off until every result is back.
                if ($urandom_range(0, 199) == 0)
                    drain_results();

                r = $urandom_range(0, 99);
                if (counted == 0)
                    cmd = CMD_INIT;
                else if (tphase == PH_STANDBY)
                begin
                    if (r < 85)
                        cmd = CMD_RESUME;
                    else if (r < 97)
                        cmd = CMD_SAMPLE;
                    else
                        cmd = CMD_INIT;
                end
                else if (r < 3)
                    cmd = CMD_INIT;
                else if (r < 6)
                    cmd = CMD_RESUME;
                else
                    cmd = CMD_SAMPLE;
                // A resume outside standby is ignored; do not count it.
                effective = !(cmd == CMD_RESUME && tphase != PH_STANDBY);

                send_item(cmd, random_cte(), 1'b0, '0, '0, '0, PH_OFF);
                if (effective)
                    counted++;
            end
        end

        // Wind down: release back-pressure, wait for the last results, then
        // give stray beats TAIL_CYCLES to show up.
        quiet_sink <= 1'b1;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
